// ===== rtl/paid_pkg.sv =====
package paid_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int DATA_W    = 32;
	localparam int FUNC_W    = 3;
	localparam int STAT_W    = 2;

	typedef enum logic [FUNC_W-1:0] {
		OP_CLEAR  = 3'd0,
		OP_APPEND = 3'd1,
		OP_READ   = 3'd2,
		OP_INSERT = 3'd3,
		OP_DELETE = 3'd4
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_RUN,
		FSM_FINISH
	} fsm_t;

endpackage

// ===== rtl/positional_array_insert_delete.sv =====
// channel | dir | tdata (lsb up)                      | tuser
// s_*     | in  | value[31:0], position[PW-1:0], pad  | func[2:0]
// m_*     | out | data[31:0], count[PW-1:0], pad      | status[1:0]
//
// clear, refused requests and unused codes go from accept straight to the result
// read and append touch one entry; insert and delete walk from the position to the end
// entries move one per cycle through the entry memory
// (one read port, one write port, registered read data)
// reset clears the count and the handshake state; entry memory is not cleared
// a new request is taken while the previous result still waits in the output register

module positional_array_insert_delete #(
	parameter int DEPTH = paid_pkg::DEPTH_DEF,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int PW    = $clog2(DEPTH + 1),
	localparam int IN_W  = ((paid_pkg::DATA_W + PW + 7) / 8) * 8,
	localparam int OUT_W = ((paid_pkg::DATA_W + PW + 7) / 8) * 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [IN_W-1:0]             s_tdata,   // value, position, zero pad
	input  logic [paid_pkg::FUNC_W-1:0] s_tuser,   // func
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [OUT_W-1:0]            m_tdata,   // data, count, zero pad
	output logic [paid_pkg::STAT_W-1:0] m_tuser    // status
);

	localparam logic [PW-1:0] ONE   = PW'(1);
	localparam logic [PW-1:0] LIMIT = PW'(DEPTH);

	paid_pkg::fsm_t state_q, state_d;

	// request fields
	logic signed [paid_pkg::DATA_W-1:0] in_value;
	logic [PW-1:0]                      in_pos;
	paid_pkg::op_t                      in_op;

	assign in_value = s_tdata[paid_pkg::DATA_W-1:0];
	assign in_pos   = s_tdata[paid_pkg::DATA_W +: PW];
	assign in_op    = paid_pkg::op_t'(s_tuser);

	// decode results
	paid_pkg::status_t dec_status;
	logic              dec_run;
	logic              dec_ins;
	logic [PW-1:0]     dec_pos, dec_end, dec_fill;

	logic [PW-1:0] fill_q;

	// working registers
	logic                               ins_q;
	logic [PW-1:0]                      pos_q, idx_q, end_q;
	logic signed [paid_pkg::DATA_W-1:0] carry_q;
	paid_pkg::status_t                  res_status_q;
	logic signed [paid_pkg::DATA_W-1:0] res_data_q;
	logic [PW-1:0]                      res_fill_q;

	// read pipeline stage
	logic                               rv_s1;
	logic [PW-1:0]                      ra_s1;
	logic signed [paid_pkg::DATA_W-1:0] rdata_s1;

	// entry memory
	logic signed [paid_pkg::DATA_W-1:0] mem [DEPTH];
	logic                               mem_re, mem_we;
	logic [AW-1:0]                      mem_waddr;
	logic signed [paid_pkg::DATA_W-1:0] mem_wdata;

	// output register
	logic                        m_tvalid_q;
	logic [OUT_W-1:0]            m_tdata_q;
	logic [paid_pkg::STAT_W-1:0] m_tuser_q;
	logic                        out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// check the request against the count
	always_comb begin
		dec_status = paid_pkg::ST_OK;
		dec_run    = 1'b0;
		dec_ins    = 1'b0;
		dec_pos    = in_pos;
		dec_end    = in_pos;
		dec_fill   = fill_q;
		unique case (in_op)
			paid_pkg::OP_CLEAR: begin
				dec_fill = '0;
			end
			paid_pkg::OP_APPEND: begin
				// same as an insert at the end
				if (fill_q == LIMIT) begin
					dec_status = paid_pkg::ST_FULL;
				end else begin
					dec_run  = 1'b1;
					dec_ins  = 1'b1;
					dec_pos  = fill_q;
					dec_end  = fill_q;
					dec_fill = fill_q + ONE;
				end
			end
			paid_pkg::OP_READ: begin
				if (fill_q == '0) begin
					dec_status = paid_pkg::ST_EMPTY;
				end else if (in_pos >= fill_q) begin
					dec_status = paid_pkg::ST_BADPOS;
				end else begin
					dec_run = 1'b1;
				end
			end
			paid_pkg::OP_INSERT: begin
				// ripple up from position through the old last entry
				if (fill_q == LIMIT) begin
					dec_status = paid_pkg::ST_FULL;
				end else if (in_pos > fill_q) begin
					dec_status = paid_pkg::ST_BADPOS;
				end else begin
					dec_run  = 1'b1;
					dec_ins  = 1'b1;
					dec_end  = fill_q;
					dec_fill = fill_q + ONE;
				end
			end
			paid_pkg::OP_DELETE: begin
				// read position for the result, then pull later entries down
				if (fill_q == '0) begin
					dec_status = paid_pkg::ST_EMPTY;
				end else if (in_pos >= fill_q) begin
					dec_status = paid_pkg::ST_BADPOS;
				end else begin
					dec_run  = 1'b1;
					dec_end  = fill_q - ONE;
					dec_fill = fill_q - ONE;
				end
			end
			default: begin
				// unused codes leave everything as it is
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= paid_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory control
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = ra_s1[AW-1:0];
		mem_wdata = carry_q;
		unique case (state_q)
			paid_pkg::FSM_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = dec_run ? paid_pkg::FSM_RUN : paid_pkg::FSM_FINISH;
				end
			end
			paid_pkg::FSM_RUN: begin
				mem_re = (idx_q <= end_q);
				if (rv_s1) begin
					if (ins_q) begin
						// write the carried value where the old one was just read
						mem_we = 1'b1;
					end else if (ra_s1 != pos_q) begin
						// delete: move the entry one place down
						mem_we    = 1'b1;
						mem_waddr = AW'(ra_s1 - ONE);
						mem_wdata = rdata_s1;
					end
				end
				if (idx_q > end_q && !rv_s1) begin
					state_d = paid_pkg::FSM_FINISH;
				end
			end
			paid_pkg::FSM_FINISH: begin
				if (out_free) begin
					state_d = paid_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = paid_pkg::FSM_IDLE;
			end
		endcase
	end

	// memory: read address always runs ahead of the write address
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_s1 <= mem[idx_q[AW-1:0]];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1      <= 1'b0;
			fill_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			rv_s1 <= mem_re;
			if (state_q == paid_pkg::FSM_FINISH && out_free) begin
				fill_q     <= res_fill_q;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (state_q == paid_pkg::FSM_IDLE && s_tvalid) begin
			ins_q        <= dec_ins;
			pos_q        <= dec_pos;
			idx_q        <= dec_pos;
			end_q        <= dec_end;
			carry_q      <= in_value;
			res_status_q <= dec_status;
			res_data_q   <= '0;
			res_fill_q   <= dec_fill;
		end
		if (mem_re) begin
			idx_q <= idx_q + ONE;
			ra_s1 <= idx_q;
		end
		if (state_q == paid_pkg::FSM_RUN && rv_s1) begin
			if (ins_q) begin
				carry_q <= rdata_s1;
			end else if (ra_s1 == pos_q) begin
				res_data_q <= rdata_s1;
			end
		end
		if (state_q == paid_pkg::FSM_FINISH && out_free) begin
			m_tdata_q <= OUT_W'({res_fill_q, res_data_q});
			m_tuser_q <= res_status_q;
		end
	end

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LIMIT)
		else $error("count above depth");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == paid_pkg::FSM_IDLE) |-> !mem_we)
		else $error("memory write outside a shift");

	a_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_re && mem_we) |-> (idx_q[AW-1:0] != mem_waddr))
		else $error("read and write hit the same entry");

	a_count_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == paid_pkg::FSM_FINISH && out_free)
		|=> (m_tdata_q[paid_pkg::DATA_W +: PW] == fill_q))
		else $error("reported count differs from stored count");

	a_refused_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == paid_pkg::FSM_FINISH && res_status_q != paid_pkg::ST_OK)
		|-> (res_fill_q == fill_q && res_data_q == '0))
		else $error("refused request changed the array");

endmodule
